/* hdl/rmq_pkg.sv */
// shared constants for the rotation matrix to quaternion pipeline
// no dependencies
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // extra bits so the branch vector never overflows
    localparam int V_EXTRA   = 3;
    localparam int LANES     = 4;
    // the largest normalised magnitude sits in [2^30, 2^31)
    localparam int NORM_MSB  = 30;
    localparam int NORM_BITS = 31;
    localparam int SQ_BITS   = 2 * NORM_BITS;
    localparam int SUM_BITS  = 64;
    localparam int ROOT_BITS = 32;
    localparam int ROOT_REM  = ROOT_BITS + 3;
    localparam int SQRT_PER_STG = 2;
    localparam int SQRT_STG  = ROOT_BITS / SQRT_PER_STG;
    localparam int DIV_PER_STG  = 2;

endpackage

/* hdl/rmq_select.sv */
// branch selection on trace against largest diagonal, builds the scaled vector
// depends on rmq_pkg
module rmq_select
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic signed [DATA_WIDTH-1:0]          col0_x,
    input  logic signed [DATA_WIDTH-1:0]          col0_y,
    input  logic signed [DATA_WIDTH-1:0]          col0_z,
    input  logic signed [DATA_WIDTH-1:0]          col1_x,
    input  logic signed [DATA_WIDTH-1:0]          col1_y,
    input  logic signed [DATA_WIDTH-1:0]          col1_z,
    input  logic signed [DATA_WIDTH-1:0]          col2_x,
    input  logic signed [DATA_WIDTH-1:0]          col2_y,
    input  logic signed [DATA_WIDTH-1:0]          col2_z,
    output logic signed [DATA_WIDTH+V_EXTRA-1:0]  v_w,
    output logic signed [DATA_WIDTH+V_EXTRA-1:0]  v_x,
    output logic signed [DATA_WIDTH+V_EXTRA-1:0]  v_y,
    output logic signed [DATA_WIDTH+V_EXTRA-1:0]  v_z,
    output logic                                  bad
);

    localparam int VW = DATA_WIDTH + V_EXTRA;
    localparam logic signed [VW-1:0] ONE = VW'(64'd1 << FRAC_BITS);

    logic signed [VW-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
    logic signed [VW-1:0] t, r;

    assign m0 = VW'(col0_x);
    assign m1 = VW'(col0_y);
    assign m2 = VW'(col0_z);
    assign m3 = VW'(col1_x);
    assign m4 = VW'(col1_y);
    assign m5 = VW'(col1_z);
    assign m6 = VW'(col2_x);
    assign m7 = VW'(col2_y);
    assign m8 = VW'(col2_z);
    assign t  = m0 + m4 + m8;

    always_comb
    begin
        if (!t[VW-1] && (t != '0))
        begin
            r   = ONE + t;
            v_w = r;
            v_x = m5 - m7;
            v_y = m6 - m2;
            v_z = m1 - m3;
        end
        else if ((m0 > m4) && (m0 > m8))
        begin
            r   = ONE + m0 - m4 - m8;
            v_w = m5 - m7;
            v_x = r;
            v_y = m1 + m3;
            v_z = m6 + m2;
        end
        else if (m4 > m8)
        begin
            r   = ONE - m0 + m4 - m8;
            v_w = m6 - m2;
            v_x = m1 + m3;
            v_y = r;
            v_z = m5 + m7;
        end
        else
        begin
            r   = ONE - m0 - m4 + m8;
            v_w = m1 - m3;
            v_x = m6 + m2;
            v_y = m5 + m7;
            v_z = r;
        end
    end

    assign bad = r[VW-1] || (r == '0);

endmodule

/* hdl/rotation_matrix_to_quaternion_top.sv */
// rotation matrix to unit quaternion, top level pipeline
// depends on rmq_pkg and rmq_select
// stages in order: select, magnitude, shift, squares, sum, square root, divider setup, dividers, output
// throughput: one beat per cycle while out_stall is low; the square root and dividers are pipelined, two bits a stage
// a stalled stage holds and bubbles ahead of it close up
// reset clears all stage valid bits, the datapath registers are not reset
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [DATA_WIDTH-1:0]  col0_x,
    input  logic signed [DATA_WIDTH-1:0]  col0_y,
    input  logic signed [DATA_WIDTH-1:0]  col0_z,
    input  logic signed [DATA_WIDTH-1:0]  col1_x,
    input  logic signed [DATA_WIDTH-1:0]  col1_y,
    input  logic signed [DATA_WIDTH-1:0]  col1_z,
    input  logic signed [DATA_WIDTH-1:0]  col2_x,
    input  logic signed [DATA_WIDTH-1:0]  col2_y,
    input  logic signed [DATA_WIDTH-1:0]  col2_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  quat_w,
    output logic signed [DATA_WIDTH-1:0]  quat_x,
    output logic signed [DATA_WIDTH-1:0]  quat_y,
    output logic signed [DATA_WIDTH-1:0]  quat_z,
    output logic                          invalid
);

    localparam int VW     = DATA_WIDTH + V_EXTRA;
    localparam int MW     = DATA_WIDTH + 2;
    localparam int PW     = $clog2(MW);
    localparam int QB     = FRAC_BITS + 1;
    localparam int DV_STG = (QB + DIV_PER_STG - 1) / DIV_PER_STG;
    localparam int DWD    = NORM_BITS + FRAC_BITS + 1;
    localparam int RW     = ROOT_BITS + 1;

    localparam int S_SEL  = 0;
    localparam int S_MAG  = 1;
    localparam int S_SHF  = 2;
    localparam int S_SQR  = 3;
    localparam int S_SUM  = 4;
    localparam int S_SQ0  = 5;
    localparam int S_PRE  = S_SQ0 + SQRT_STG;
    localparam int S_DV0  = S_PRE + 1;
    localparam int S_OUT  = S_DV0 + DV_STG;
    localparam int NSTG   = S_OUT + 1;

    localparam logic [63:0] ONE64  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MAXPOS = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    // ---------------- flow control ----------------
    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- select stage ----------------
    logic signed [VW-1:0] v_next [LANES];
    logic                 bad_next;
    logic signed [VW-1:0] v_reg [LANES];
    logic                 inv0_reg;

    rmq_select #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_select (
        .col0_x (col0_x),
        .col0_y (col0_y),
        .col0_z (col0_z),
        .col1_x (col1_x),
        .col1_y (col1_y),
        .col1_z (col1_z),
        .col2_x (col2_x),
        .col2_y (col2_y),
        .col2_z (col2_z),
        .v_w    (v_next[0]),
        .v_x    (v_next[1]),
        .v_y    (v_next[2]),
        .v_z    (v_next[3]),
        .bad    (bad_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[S_SEL])
        begin
            v_reg    <= v_next;
            inv0_reg <= bad_next;
        end
    end

    // ---------------- magnitude and leading one ----------------
    logic [MW-1:0] mag_next [LANES];
    logic [MW-1:0] mag_or;
    logic [PW-1:0] pos_next;
    logic [MW-1:0] mag_reg [LANES];
    logic [LANES-1:0] neg1_reg;
    logic [PW-1:0] pos_reg;
    logic          inv1_reg;

    always_comb
    begin
        mag_or = '0;
        for (int i = 0; i < LANES; i++)
        begin
            mag_next[i] = v_reg[i][VW-1] ? MW'(-v_reg[i]) : MW'(v_reg[i]);
            mag_or      = mag_or | mag_next[i];
        end
        pos_next = '0;
        for (int b = 0; b < MW; b++)
        begin
            if (mag_or[b])
            begin
                pos_next = PW'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_MAG])
        begin
            mag_reg  <= mag_next;
            pos_reg  <= pos_next;
            inv1_reg <= inv0_reg;
            for (int i = 0; i < LANES; i++)
            begin
                neg1_reg[i] <= v_reg[i][VW-1];
            end
        end
    end

    // ---------------- common shift into [2^30, 2^31) ----------------
    logic [NORM_BITS-1:0] ms_next [LANES];
    logic [NORM_BITS-1:0] ms2_reg [LANES];
    logic [LANES-1:0]     neg2_reg;
    logic                 inv2_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (int'(pos_reg) >= NORM_MSB)
            begin
                ms_next[i] = NORM_BITS'(64'(mag_reg[i]) >> (int'(pos_reg) - NORM_MSB));
            end
            else
            begin
                ms_next[i] = NORM_BITS'(64'(mag_reg[i]) << (NORM_MSB - int'(pos_reg)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SHF])
        begin
            ms2_reg  <= ms_next;
            neg2_reg <= neg1_reg;
            inv2_reg <= inv1_reg;
        end
    end

    // ---------------- squares ----------------
    logic [SQ_BITS-1:0]   sq_reg [LANES];
    logic [NORM_BITS-1:0] ms3_reg [LANES];
    logic [LANES-1:0]     neg3_reg;
    logic                 inv3_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_SQR])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sq_reg[i] <= SQ_BITS'(ms2_reg[i]) * SQ_BITS'(ms2_reg[i]);
            end
            ms3_reg  <= ms2_reg;
            neg3_reg <= neg2_reg;
            inv3_reg <= inv2_reg;
        end
    end

    // ---------------- sum of squares ----------------
    logic [SUM_BITS-1:0]  sum_reg;
    logic [NORM_BITS-1:0] ms4_reg [LANES];
    logic [LANES-1:0]     neg4_reg;
    logic                 inv4_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_SUM])
        begin
            sum_reg  <= (SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]))
                      + (SUM_BITS'(sq_reg[2]) + SUM_BITS'(sq_reg[3]));
            ms4_reg  <= ms3_reg;
            neg4_reg <= neg3_reg;
            inv4_reg <= inv3_reg;
        end
    end

    // ---------------- square root, two result bits a stage ----------------
    logic [SUM_BITS-1:0]  sq_n_reg    [SQRT_STG];
    logic [ROOT_REM-1:0]  sq_rem_reg  [SQRT_STG];
    logic [ROOT_BITS-1:0] sq_root_reg [SQRT_STG];
    logic [NORM_BITS-1:0] sq_ms_reg   [SQRT_STG][LANES];
    logic [LANES-1:0]     sq_neg_reg  [SQRT_STG];
    logic                 sq_inv_reg  [SQRT_STG];

    for (genvar k = 0; k < SQRT_STG; k++)
    begin : g_sqrt
        logic [SUM_BITS-1:0]  n_in, n_next;
        logic [ROOT_REM-1:0]  rem_in, rem_next;
        logic [ROOT_BITS-1:0] root_in, root_next;
        logic [ROOT_REM-1:0]  rem_t, trial;
        logic [NORM_BITS-1:0] ms_in [LANES];
        logic [LANES-1:0]     neg_in;
        logic                 inv_in;

        if (k == 0)
        begin : g_first
            assign n_in    = sum_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign ms_in   = ms4_reg;
            assign neg_in  = neg4_reg;
            assign inv_in  = inv4_reg;
        end
        else
        begin : g_next
            assign n_in    = sq_n_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign ms_in   = sq_ms_reg[k-1];
            assign neg_in  = sq_neg_reg[k-1];
            assign inv_in  = sq_inv_reg[k-1];
        end

        always_comb
        begin
            n_next    = n_in;
            rem_next  = rem_in;
            root_next = root_in;
            rem_t     = '0;
            trial     = '0;
            for (int j = 0; j < SQRT_PER_STG; j++)
            begin
                rem_t  = {rem_next[ROOT_REM-3:0], n_next[SUM_BITS-1:SUM_BITS-2]};
                n_next = n_next << 2;
                trial  = {1'b0, root_next, 2'b01};
                if (rem_t >= trial)
                begin
                    rem_next  = rem_t - trial;
                    root_next = {root_next[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t;
                    root_next = {root_next[ROOT_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[S_SQ0+k])
            begin
                sq_n_reg[k]    <= n_next;
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_ms_reg[k]   <= ms_in;
                sq_neg_reg[k]  <= neg_in;
                sq_inv_reg[k]  <= inv_in;
            end
        end
    end

    // ---------------- divider setup, rounding term folded into the dividend ----------------
    logic [ROOT_BITS-1:0] len;
    logic [DWD-1:0]       dvd [LANES];
    logic [RW-1:0]        pr_rem_reg [LANES];
    logic [QB-1:0]        pr_dl_reg  [LANES];
    logic [ROOT_BITS-1:0] pr_len_reg;
    logic [LANES-1:0]     pr_neg_reg;
    logic                 pr_inv_reg;

    assign len = sq_root_reg[SQRT_STG-1];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            dvd[i] = (DWD'(sq_ms_reg[SQRT_STG-1][i]) << FRAC_BITS) + DWD'(len >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_PRE])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pr_rem_reg[i] <= RW'(dvd[i][DWD-1:QB]);
                pr_dl_reg[i]  <= dvd[i][QB-1:0];
            end
            pr_len_reg <= len;
            pr_neg_reg <= sq_neg_reg[SQRT_STG-1];
            pr_inv_reg <= sq_inv_reg[SQRT_STG-1];
        end
    end

    // ---------------- four dividers, two quotient bits a stage ----------------
    logic [RW-1:0]        dv_rem_reg [DV_STG][LANES];
    logic [QB-1:0]        dv_dl_reg  [DV_STG][LANES];
    logic [QB-1:0]        dv_q_reg   [DV_STG][LANES];
    logic [ROOT_BITS-1:0] dv_len_reg [DV_STG];
    logic [LANES-1:0]     dv_neg_reg [DV_STG];
    logic                 dv_inv_reg [DV_STG];

    for (genvar k = 0; k < DV_STG; k++)
    begin : g_div
        logic [RW-1:0]        rem_in  [LANES];
        logic [QB-1:0]        dl_in   [LANES];
        logic [QB-1:0]        q_in    [LANES];
        logic [ROOT_BITS-1:0] len_in;
        logic [LANES-1:0]     neg_in;
        logic                 inv_in;
        logic [RW-1:0]        rem_next [LANES];
        logic [QB-1:0]        dl_next  [LANES];
        logic [QB-1:0]        q_next   [LANES];
        logic [RW-1:0]        rem_t;

        if (k == 0)
        begin : g_first
            assign rem_in = pr_rem_reg;
            assign dl_in  = pr_dl_reg;
            assign len_in = pr_len_reg;
            assign neg_in = pr_neg_reg;
            assign inv_in = pr_inv_reg;
            for (genvar i = 0; i < LANES; i++)
            begin : g_q
                assign q_in[i] = '0;
            end
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[k-1];
            assign dl_in  = dv_dl_reg[k-1];
            assign q_in   = dv_q_reg[k-1];
            assign len_in = dv_len_reg[k-1];
            assign neg_in = dv_neg_reg[k-1];
            assign inv_in = dv_inv_reg[k-1];
        end

        always_comb
        begin
            rem_t = '0;
            for (int i = 0; i < LANES; i++)
            begin
                rem_next[i] = rem_in[i];
                dl_next[i]  = dl_in[i];
                q_next[i]   = q_in[i];
                for (int j = 0; j < DIV_PER_STG; j++)
                begin
                    // a short last stage when the quotient width is odd
                    if (k * DIV_PER_STG + j < QB)
                    begin
                        rem_t      = {rem_next[i][RW-2:0], dl_next[i][QB-1]};
                        dl_next[i] = dl_next[i] << 1;
                        if (rem_t >= RW'(len_in))
                        begin
                            rem_next[i] = rem_t - RW'(len_in);
                            q_next[i]   = {q_next[i][QB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next[i] = rem_t;
                            q_next[i]   = {q_next[i][QB-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[S_DV0+k])
            begin
                dv_rem_reg[k] <= rem_next;
                dv_dl_reg[k]  <= dl_next;
                dv_q_reg[k]   <= q_next;
                dv_len_reg[k] <= len_in;
                dv_neg_reg[k] <= neg_in;
                dv_inv_reg[k] <= inv_in;
            end
        end
    end

    // ---------------- sign, saturation and output register ----------------
    logic [DATA_WIDTH-1:0] res_next [LANES];
    logic [DATA_WIDTH-1:0] quat_reg [LANES];
    logic                  invalid_reg;
    logic [63:0]           qq;

    always_comb
    begin
        qq = '0;
        for (int i = 0; i < LANES; i++)
        begin
            qq = 64'(dv_q_reg[DV_STG-1][i]);
            if (dv_inv_reg[DV_STG-1])
            begin
                res_next[i] = '0;
            end
            else if (dv_neg_reg[DV_STG-1][i])
            begin
                res_next[i] = DATA_WIDTH'(-qq);
            end
            else if (qq > MAXPOS)
            begin
                res_next[i] = DATA_WIDTH'(MAXPOS);
            end
            else
            begin
                res_next[i] = DATA_WIDTH'(qq);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            quat_reg    <= res_next;
            invalid_reg <= dv_inv_reg[DV_STG-1];
        end
    end

    assign quat_w  = signed'(quat_reg[0]);
    assign quat_x  = signed'(quat_reg[1]);
    assign quat_y  = signed'(quat_reg[2]);
    assign quat_z  = signed'(quat_reg[3]);
    assign invalid = invalid_reg;

    // ---------------- checks ----------------
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid) |->
            (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0))
        else $error("invalid beat with non-zero quaternion");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[S_PRE-1] && !sq_inv_reg[SQRT_STG-1]) |->
            (sq_root_reg[SQRT_STG-1][ROOT_BITS-1:ROOT_BITS-2] != 2'b00))
        else $error("length below 2^30 after normalisation");

    a_q_unit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_OUT-1] |->
            (64'(dv_q_reg[DV_STG-1][0]) <= ONE64) && (64'(dv_q_reg[DV_STG-1][1]) <= ONE64)
            && (64'(dv_q_reg[DV_STG-1][2]) <= ONE64) && (64'(dv_q_reg[DV_STG-1][3]) <= ONE64))
        else $error("quotient above one");

endmodule
